[src/gmf_pkg.sv]
// ----------------------------------------------------------------------------
// Gradient magnitude filter package
// Shared constants, codes and the command and status bundles that connect
// the controller with the datapath.
// ----------------------------------------------------------------------------
package gmf_pkg;

   localparam int MAX_WIDTH_DEF = 1024;

   // Configuration register layout.
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd900;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;
   localparam logic [CFG_W-1:0] HEIGHT_LIMIT     = 11'd1024;

   // Item kind carried on the input user bits.
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam int PIX_W = 8;
   localparam int POS_W = 10;
   localparam int SQ_W  = 17;
   localparam int OUT_DATA_W = 32;
   localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

   typedef struct packed {
      logic take;        // input word accepted this cycle
      logic rd_side;     // line stores address the neighbor columns
      logic cap_center;  // capture center and above pixels
      logic grad;        // form gx and gy
      logic root_start;  // launch the square root unit
      logic wr_upper;    // shift center into the upper line
      logic wr_middle;   // store the new pixel into the middle line
      logic out_load;    // load the result register
      logic edge_col;
      logic edge_row;
      logic frame_end;
   } gmf_cmd_type;

   typedef struct packed {
      logic root_busy;
      logic out_free;
   } gmf_stat_type;

endpackage

[src/gradient_magnitude_filter.sv]
// ----------------------------------------------------------------------------
// Gradient magnitude filter
// Central-difference gradient magnitude over a streamed frame with two
// line stores and drain words for the final row.
// ----------------------------------------------------------------------------
// A word that yields a result holds off the next word until the result is
// loaded into the output register once that is free, after the two read
// passes over the line stores and the nine-step square root unit. First-row
// pixels make only the two read passes; ignored words never hold the input.
// Reset is synchronous; the line stores are not cleared and need no sweep.
module gradient_magnitude_filter #(
   parameter int MAX_WIDTH = gmf_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // pixel[7:0]
   input  logic                          req_tuser,  // func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // magnitude[7:0], column[17:8], row[27:18], zero fill[31:28]
   output logic [gmf_pkg::OUT_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast,  // frame_end
   input  logic                          csr_we,
   input  logic [gmf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gmf_pkg::CFG_W-1:0]     csr_wdata
);
   import gmf_pkg::*;

   gmf_cmd_type  cmd;
   gmf_stat_type stat;
   logic [$clog2(MAX_WIDTH)-1:0] col;
   logic [POS_W-1:0] res_row;

   gmf_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .col        (col),
      .res_row    (res_row)
   );

   gmf_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .col        (col),
      .res_row    (res_row),
      .pixel      (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result register loaded while still holding a word");

   a_take_root_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> !stat.root_busy)
      else $error("word accepted while the square root unit is busy");

   a_root_starts : assert property (@(posedge clock) disable iff (reset)
      cmd.root_start |=> stat.root_busy)
      else $error("square root unit did not start");

   a_shift_lines : assert property (@(posedge clock) disable iff (reset)
      cmd.wr_middle |-> cmd.wr_upper)
      else $error("middle line written without shifting the upper line");
`endif

endmodule

[src/gmf_ram.sv]
// ----------------------------------------------------------------------------
// Generic line store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/gmf_isqrt.sv]
// ----------------------------------------------------------------------------
// Gradient magnitude square root unit
// Squares gx and gy, then finds floor(sqrt) one result bit per cycle.
// ----------------------------------------------------------------------------
module gmf_isqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [gmf_pkg::PIX_W-1:0] gx,
   input  logic [gmf_pkg::PIX_W-1:0] gy,
   output logic                      busy,
   output logic [gmf_pkg::PIX_W-1:0] root
);
   import gmf_pkg::*;

   localparam int RW = SQ_W + 1;
   localparam logic [SQ_W-1:0] BIT_TOP = SQ_W'(1) << (SQ_W - 1);

   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [RW-1:0]   res_ff, res_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic            busy_ff, busy_in;
   logic [2*PIX_W-1:0] sq_x, sq_y;
   logic [RW-1:0]   trial;

   assign sq_x  = (2*PIX_W)'(gx) * (2*PIX_W)'(gx);
   assign sq_y  = (2*PIX_W)'(gy) * (2*PIX_W)'(gy);
   assign trial = res_ff + RW'(bit_ff);

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = SQ_W'(sq_x) + SQ_W'(sq_y);
         res_in  = '0;
         bit_in  = BIT_TOP;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (RW'(rem_ff) >= trial) begin
            rem_in = rem_ff - trial[SQ_W-1:0];
            res_in = (res_ff >> 1) + RW'(bit_ff);
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // The step with the lowest bit is the last one.
         if (bit_ff == SQ_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = (res_ff > RW'(MAG_SAT)) ? MAG_SAT : res_ff[PIX_W-1:0];

endmodule

[src/gmf_datapath.sv]
// ----------------------------------------------------------------------------
// Gradient magnitude datapath
// Line stores, gradient registers, square root unit and result register.
// ----------------------------------------------------------------------------
module gmf_datapath #(
   parameter int MAX_WIDTH = gmf_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  gmf_pkg::gmf_cmd_type           cmd,
   output gmf_pkg::gmf_stat_type          stat,
   input  logic [$clog2(MAX_WIDTH)-1:0]   col,
   input  logic [gmf_pkg::POS_W-1:0]      res_row,
   input  logic [gmf_pkg::PIX_W-1:0]      pixel,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [gmf_pkg::OUT_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import gmf_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic [PIX_W-1:0] pix_ff, center_ff, above_ff, gx_ff, gy_ff;
   logic [PIX_W-1:0] gx_in, gy_in;
   logic [PIX_W-1:0] up_rd, mid_rd, root;
   logic [AW-1:0]    up_addr, mid_addr;
   logic             root_busy;
   logic [31:0]      col_wide;
   logic             out_free;
   logic             rsp_tvalid_ff;
   logic [OUT_DATA_W-1:0] rsp_tdata_ff;
   logic             rsp_tlast_ff;

   function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // At the edges the neighbor pass rereads column x so no address leaves the store.
   always_comb begin
      up_addr  = col;
      mid_addr = col;
      if (cmd.rd_side && !cmd.edge_col) begin
         up_addr  = col - AW'(1);
         mid_addr = col + AW'(1);
      end
   end

   gmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (cmd.wr_upper),
      .wr_addr (col),
      .wr_data (center_ff),
      .rd_addr (up_addr),
      .rd_data (up_rd)
   );

   gmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (cmd.wr_middle),
      .wr_addr (col),
      .wr_data (pix_ff),
      .rd_addr (mid_addr),
      .rd_data (mid_rd)
   );

   // During the gradient step the read ports hold the right and left neighbors.
   assign gx_in = cmd.edge_col ? center_ff : abs_diff(mid_rd, up_rd);
   assign gy_in = cmd.edge_row ? center_ff : abs_diff(pix_ff, above_ff);

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pix_ff <= pixel;
      end
      if (cmd.cap_center) begin
         center_ff <= mid_rd;
         above_ff  <= up_rd;
      end
      if (cmd.grad) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
   end

   gmf_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.root_start),
      .gx    (gx_ff),
      .gy    (gy_ff),
      .busy  (root_busy),
      .root  (root)
   );

   assign col_wide = 32'(col);
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_tdata_ff <= {{(OUT_DATA_W - PIX_W - 2*POS_W){1'b0}}, res_row,
                          col_wide[POS_W-1:0], root};
         rsp_tlast_ff <= cmd.frame_end;
      end
   end

   assign stat.root_busy = root_busy;
   assign stat.out_free  = out_free;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

[src/gmf_ctrl.sv]
// ----------------------------------------------------------------------------
// Gradient magnitude controller
// Frame position, configuration registers and the per-word sequencer.
// ----------------------------------------------------------------------------
module gmf_ctrl #(
   parameter int MAX_WIDTH = gmf_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,
   input  logic                            csr_we,
   input  logic [gmf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gmf_pkg::CFG_W-1:0]       csr_wdata,
   output gmf_pkg::gmf_cmd_type            cmd,
   input  gmf_pkg::gmf_stat_type           stat,
   output logic [$clog2(MAX_WIDTH)-1:0]    col,
   output logic [gmf_pkg::POS_W-1:0]       res_row
);
   import gmf_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int EW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

   typedef enum logic [2:0] {
      S_IDLE, S_RD0, S_RD1, S_RD2, S_START, S_ROOT, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_SKIP, OP_ROW0, OP_MID, OP_DRAIN
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in, op_now;
   logic [CFG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [AW-1:0]    col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in, res_row_ff, res_row_in;
   logic             drain_ff, drain_in;
   logic             edge_col_ff, edge_col_in, edge_row_ff, edge_row_in;
   logic             last_ff, last_in;
   logic [EW-1:0]    w_eff, col_next;
   logic [CFG_W-1:0] h_eff, row_next;
   logic             accept, advance;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = EW'(1);
      end else if (EW'(width_ff) > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = EW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = CFG_W'(1);
      end else if (height_ff > HEIGHT_LIMIT) begin
         h_eff = HEIGHT_LIMIT;
      end else begin
         h_eff = height_ff;
      end
   end

   assign accept   = req_tvalid && (state_ff == S_IDLE);
   assign col_next = EW'(col_ff) + EW'(1);
   assign row_next = CFG_W'(row_ff) + CFG_W'(1);

   always_comb begin
      if (req_tuser == FUNC_PIXEL) begin
         op_now = drain_ff ? OP_SKIP : ((row_ff == '0) ? OP_ROW0 : OP_MID);
      end else begin
         op_now = drain_ff ? OP_DRAIN : OP_SKIP;
      end
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      drain_in    = drain_ff;
      edge_col_in = edge_col_ff;
      edge_row_in = edge_row_ff;
      last_in     = last_ff;
      res_row_in  = res_row_ff;
      advance     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && op_now != OP_SKIP) begin
               state_in    = S_RD0;
               op_in       = op_now;
               last_in     = col_next >= w_eff;
               edge_col_in = (col_ff == '0) || (col_next >= w_eff);
               edge_row_in = (op_now == OP_DRAIN) || (row_ff == POS_W'(1));
               res_row_in  = (op_now == OP_DRAIN) ? POS_W'(h_eff - CFG_W'(1))
                                                  : row_ff - POS_W'(1);
            end
         end
         S_RD0: state_in = S_RD1;
         S_RD1: state_in = S_RD2;
         S_RD2: begin
            if (op_ff == OP_ROW0) begin
               state_in = S_IDLE;
               advance  = 1'b1;
            end else begin
               state_in = S_START;
            end
         end
         S_START: state_in = S_ROOT;
         S_ROOT: begin
            if (!stat.root_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
               advance  = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (advance) begin
         if (col_next >= w_eff) begin
            col_in = '0;
            if (op_ff == OP_DRAIN) begin
               drain_in = 1'b0;
            end else if (row_next >= h_eff) begin
               row_in   = '0;
               drain_in = 1'b1;
            end else begin
               row_in = row_ff + POS_W'(1);
            end
         end else begin
            col_in = col_ff + AW'(1);
         end
      end

      // A register write restarts the frame; the line stores are kept.
      if (csr_we && (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT)) begin
         if (csr_index == REG_FRAME_WIDTH) begin
            width_in = csr_wdata;
         end else begin
            height_in = csr_wdata;
         end
         col_in   = '0;
         row_in   = '0;
         drain_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= FRAME_WIDTH_RST;
         height_ff <= FRAME_HEIGHT_RST;
         col_ff    <= '0;
         row_ff    <= '0;
         drain_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         drain_ff  <= drain_in;
      end
      op_ff       <= op_in;
      edge_col_ff <= edge_col_in;
      edge_row_ff <= edge_row_in;
      last_ff     <= last_in;
      res_row_ff  <= res_row_in;
   end

   always_comb begin
      cmd            = '0;
      cmd.take       = accept;
      cmd.rd_side    = (state_ff == S_RD1);
      cmd.cap_center = (state_ff == S_RD1);
      cmd.grad       = (state_ff == S_RD2);
      cmd.root_start = (state_ff == S_START);
      cmd.edge_col   = edge_col_ff;
      cmd.edge_row   = edge_row_ff;
      cmd.frame_end  = (op_ff == OP_DRAIN) && last_ff;
      if (state_ff == S_RD2 && op_ff == OP_ROW0) begin
         cmd.wr_upper  = 1'b1;
         cmd.wr_middle = 1'b1;
      end
      if (state_ff == S_OUT && stat.out_free) begin
         cmd.out_load  = 1'b1;
         cmd.wr_upper  = 1'b1;
         cmd.wr_middle = (op_ff == OP_MID);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign col        = col_ff;
   assign res_row    = res_row_ff;

endmodule

[bench/gradient_magnitude_filter_test.sv]
// ----------------------------------------------------------------------------
// Gradient magnitude filter testbench
// Streams frames of pixels and drain words into the filter under random
// idling on both channels. It checks every result word against a predictor
// of the central-difference gradient kept in step with the stream.
// ----------------------------------------------------------------------------
module gradient_magnitude_filter_test;
   import gmf_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int SETTLE = 24;
   localparam int ITEM_TARGET = 650;
   localparam int unsigned SIZE_LIMIT = 1024;

   // Index values that decode to no register.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] mag;
      logic [9:0] col;
      logic [9:0] row;
      logic       last;
   } grad_result_type;

   typedef enum logic { ROW_WORD, ROW_CSR } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CFG_W-1:0]     value;
      logic                 func;
      logic [7:0]           pix;
      logic [11:0]          count;
      logic                 typed;
      grad_result_type      fixed;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  req_tuser = FUNC_PIXEL;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_FRAME_WIDTH;
   logic [CFG_W-1:0]      csr_wdata = '0;

   gradient_magnitude_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Predictor state: two line stores, frame position and the register copies.
   logic [7:0]       top_line [0:SIZE_LIMIT-1];
   logic [7:0]       mid_line [0:SIZE_LIMIT-1];
   int unsigned      col_cnt = 0;
   int unsigned      row_cnt = 0;
   bit               draining = 1'b0;
   logic [CFG_W-1:0] width_reg = FRAME_WIDTH_RST;
   logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;

   grad_result_type  pending_results [$];
   stim_row_type     directed [$];
   int unsigned      cycle_count = 0;
   int               mismatches = 0;
   int               items_sent = 0;
   bit               calm = 1'b0;
   int               stall_left = 0;

   function automatic int unsigned clamp_size(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > SIZE_LIMIT) return SIZE_LIMIT;
      return v;
   endfunction

   function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [7:0] root_sat(int unsigned v);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return (r > 255) ? MAG_SAT : r[7:0];
   endfunction

   // Magnitude for column x of the row held in mid_line; shifts that column up.
   function automatic logic [7:0] column_mag(int unsigned x, int unsigned w, bit edge_row,
                                             logic [7:0] below, bit store_below);
      int unsigned center, gx, gy;
      center = mid_line[x];
      if (x == 0 || x + 1 >= w) gx = center;
      else gx = abs_diff(mid_line[x + 1], top_line[x - 1]);
      gy = edge_row ? center : abs_diff(below, top_line[x]);
      top_line[x] = center[7:0];
      if (store_below) mid_line[x] = below;
      return root_sat(gx * gx + gy * gy);
   endfunction

   function automatic bit predict_gradient(logic func, logic [7:0] pix,
                                           output grad_result_type res);
      int unsigned w, h, x;
      bit got;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      got = 1'b0;
      res = '0;
      if (col_cnt >= w) col_cnt = 0;
      x = col_cnt;
      if (func == FUNC_PIXEL) begin
         if (draining) return 1'b0;
         if (row_cnt >= h) row_cnt = 0;
         if (row_cnt > 0) begin
            res.mag = column_mag(x, w, row_cnt == 1, pix, 1'b1);
            res.col = x[9:0];
            res.row = 10'(row_cnt - 1);
            got = 1'b1;
         end else begin
            top_line[x] = mid_line[x];
            mid_line[x] = pix;
         end
         col_cnt = x + 1;
         if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) begin
               row_cnt = 0;
               draining = 1'b1;
            end
         end
         return got;
      end
      if (!draining) return 1'b0;
      res.mag = column_mag(x, w, 1'b1, 8'd0, 1'b0);
      res.col = x[9:0];
      res.row = 10'(h - 1);
      res.last = (x + 1 >= w);
      col_cnt = x + 1;
      if (col_cnt >= w) begin
         col_cnt = 0;
         draining = 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] rand_pixel();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic add_word(logic func, logic [7:0] pix, int count);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WORD;
      row.func = func;
      row.pix = pix;
      row.count = 12'(count);
      directed.push_back(row);
   endtask

   task automatic add_word_exp(logic func, logic [7:0] pix, logic [7:0] mag,
                               logic [9:0] col, logic [9:0] row_num, logic last);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WORD;
      row.func = func;
      row.pix = pix;
      row.count = 1;
      row.typed = 1'b1;
      row.fixed = {mag, col, row_num, last};
      directed.push_back(row);
   endtask

   task automatic add_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      stim_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.idx = idx;
      row.value = value;
      directed.push_back(row);
   endtask

   // Offers one word after a random gap and updates the predictor when it is
   // taken. A fixed expectation, where given, stands in for the predicted one.
   task automatic send_word(logic func, logic [7:0] pix, bit typed,
                            grad_result_type fixed);
      int gap;
      bit got;
      grad_result_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      got = predict_gradient(func, pix, res);
      if (typed) pending_results.push_back(fixed);
      else if (got) pending_results.push_back(res);
      items_sent++;
   endtask

   // Holds off the sender until every result is in and the block has settled.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
         if (idx == REG_FRAME_WIDTH) width_reg = value;
         else height_reg = value;
         col_cnt = 0;
         row_cnt = 0;
         draining = 1'b0;
      end
   endtask

   // One setting, then one or two frames with stray words mixed in; a frame
   // is sometimes cut short, and the next setting restarts the block.
   task automatic run_phase(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv);
      int unsigned w, h, total, cut, pause_at, k;
      int nframes, f, pick;
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 7);
      if (pick == 0) write_reg(REG_FRAME_WIDTH, wv);
      else if (pick == 1) write_reg(REG_FRAME_HEIGHT, hv);
      else if (pick < 5) begin
         write_reg(REG_FRAME_WIDTH, wv);
         write_reg(REG_FRAME_HEIGHT, hv);
      end else begin
         write_reg(REG_FRAME_HEIGHT, hv);
         write_reg(REG_FRAME_WIDTH, wv);
      end
      nframes = ($urandom_range(0, 3) == 0) ? 2 : 1;
      for (f = 0; f < nframes; f++) begin
         w = clamp_size(width_reg);
         h = clamp_size(height_reg);
         total = w * h + w;
         cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
         pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
         for (k = 0; k < cut; k++) begin
            if (k == pause_at)
               write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE : REG_UNUSED,
                         CFG_W'($urandom_range(0, 2047)));
            if (k < w * h) begin
               if ($urandom_range(0, 24) == 0)
                  send_word(FUNC_DRAIN, rand_pixel(), 1'b0, '0);
               send_word(FUNC_PIXEL, rand_pixel(), 1'b0, '0);
            end else begin
               if ($urandom_range(0, 19) == 0)
                  send_word(FUNC_PIXEL, rand_pixel(), 1'b0, '0);
               send_word(FUNC_DRAIN, rand_pixel(), 1'b0, '0);
            end
         end
         if (cut < total) break;
      end
   endtask

   // Result side: random stalls, and the comparison of every taken word.
   always @(posedge clock) begin : check_results
      grad_result_type got, want;
      int gap;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         gap = pick_gap();
         rsp_tready <= (gap == 0);
         stall_left <= (gap > 0) ? gap - 1 : 0;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[17:8], rsp_tdata[27:18], rsp_tlast};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("cycle %0d: unexpected result word %h last %0d",
                        cycle_count, rsp_tdata, rsp_tlast);
         end else begin
            want = pending_results.pop_front();
            if (got != want || rsp_tdata[31:28] != 4'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("cycle %0d: expected mag %0d col %0d row %0d last %0d, %s",
                           cycle_count, want.mag, want.col, want.row, want.last,
                           $sformatf("got mag %0d col %0d row %0d last %0d fill %h",
                                     got.mag, got.col, got.row, got.last,
                                     rsp_tdata[31:28]));
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      int i, n;
      logic [CFG_W-1:0] wv, hv;
      int pick;

      // Right after reset a drain word and first-row pixels yield nothing.
      add_word(FUNC_DRAIN, 8'd0, 1);
      add_word(FUNC_PIXEL, 8'd200, 3);
      // A 4x3 frame, its drain and one stray drain word.
      add_csr(REG_FRAME_WIDTH, 11'd4);
      add_csr(REG_FRAME_HEIGHT, 11'd3);
      add_word(FUNC_PIXEL, 8'd10, 1);
      add_word(FUNC_PIXEL, 8'd20, 1);
      add_word(FUNC_PIXEL, 8'd30, 1);
      add_word(FUNC_PIXEL, 8'd40, 1);
      add_word_exp(FUNC_PIXEL, 8'd255, 8'd14, 10'd0, 10'd0, 1'b0);
      add_word(FUNC_PIXEL, 8'd255, 3);
      add_word(FUNC_PIXEL, 8'd0, 4);
      add_word(FUNC_DRAIN, 8'd0, 3);
      add_word_exp(FUNC_DRAIN, 8'd255, 8'd0, 10'd3, 10'd2, 1'b1);
      add_word(FUNC_DRAIN, 8'd0, 1);
      // Single pixel frame; a pixel during the drain is ignored.
      add_csr(REG_FRAME_WIDTH, 11'd1);
      add_csr(REG_FRAME_HEIGHT, 11'd1);
      add_word(FUNC_PIXEL, 8'd255, 1);
      add_word(FUNC_PIXEL, 8'd9, 1);
      add_word_exp(FUNC_DRAIN, 8'd0, 8'd255, 10'd0, 10'd0, 1'b1);
      // Zero sizes behave as one.
      add_csr(REG_FRAME_WIDTH, 11'd0);
      add_csr(REG_FRAME_HEIGHT, 11'd0);
      add_word(FUNC_PIXEL, 8'd100, 1);
      add_word_exp(FUNC_DRAIN, 8'd0, 8'd141, 10'd0, 10'd0, 1'b1);
      // A write to an index with no register leaves the frame running.
      add_csr(REG_FRAME_WIDTH, 11'd2);
      add_csr(REG_FRAME_HEIGHT, 11'd2);
      add_word(FUNC_PIXEL, 8'd50, 1);
      add_word(FUNC_PIXEL, 8'd60, 1);
      add_csr(REG_UNUSED, 11'd2047);
      add_word_exp(FUNC_PIXEL, 8'd70, 8'd70, 10'd0, 10'd0, 1'b0);
      add_word(FUNC_PIXEL, 8'd80, 1);
      add_word(FUNC_DRAIN, 8'd0, 2);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed.size(); i++) begin
         row = directed[i];
         if (row.kind == ROW_CSR) write_reg(row.idx, row.value);
         else for (n = 0; n < row.count; n++)
            send_word(row.func, row.pix, row.typed, row.fixed);
      end

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            wv = CFG_W'($urandom_range(1, 8));
            hv = CFG_W'($urandom_range(1, 5));
         end else if (pick < 85) begin
            wv = CFG_W'($urandom_range(9, 40));
            hv = CFG_W'($urandom_range(1, 3));
         end else if (pick < 93) begin
            wv = CFG_W'($urandom_range(0, 3));
            hv = CFG_W'($urandom_range(0, 3));
         end else begin
            wv = CFG_W'($urandom_range(1, 4));
            hv = CFG_W'($urandom_range(6, 12));
         end
         run_phase(wv, hv);
      end

      wait_idle();
      if (mismatches == 0 && pending_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
src/gmf_pkg.sv
src/gmf_ram.sv
src/gmf_isqrt.sv
src/gmf_datapath.sv
src/gmf_ctrl.sv
src/gradient_magnitude_filter.sv
bench/gradient_magnitude_filter_test.sv
